// File: sv/bb3_pkg.sv
// Shared constants, command/status types and divisor table for the 3x3 box blur.
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 13;
    localparam int ROW_W         = 12;
    localparam int HEIGHT_CAP    = 4096;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 13;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int NUM_CH  = 3;
    localparam int CH_W    = 8;
    localparam int PIX_W   = NUM_CH * CH_W;
    localparam int SUM_W   = 12;
    localparam int CNT_W   = 4;
    localparam int FRAC_W  = 16;
    localparam int RECIP_W = FRAC_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;

    typedef struct packed {
        logic       rd_en;
        logic       capture;
        logic       shift;
        logic       sum;
        logic       clr;
        logic       acc;
        logic       mul;
        logic       load_out;
        logic [2:0] col_mask;
        logic [2:0] row_mask;
        logic       frame_end;
        logic       run_end;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // ceil(2^16 / n); exact floor division for sums up to 9 * 255
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd6:    r = 17'd10923;
            4'd9:    r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

// File: sv/bb3_stream_if.sv
// Request and result channel interfaces of the 3x3 box blur.
interface bb3_in_if;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [bb3_pkg::CH_W-1:0] in_red;
    logic [bb3_pkg::CH_W-1:0] in_green;
    logic [bb3_pkg::CH_W-1:0] in_blue;

    modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
    modport sink (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

interface bb3_out_if;
    logic                     valid;
    logic                     ready;
    logic [bb3_pkg::CH_W-1:0] out_red;
    logic [bb3_pkg::CH_W-1:0] out_green;
    logic [bb3_pkg::CH_W-1:0] out_blue;
    logic                     frame_end;
    logic                     run_end;

    modport source (output valid, out_red, out_green, out_blue, frame_end, run_end,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, frame_end, run_end,
                  output ready);
endinterface

// File: sv/bb3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bb3_ram #(
    parameter int  WIDTH = 24,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/bb3_datapath.sv
// Datapath: row buffers, 3x3 window, accumulators, reciprocal multiply, output register.
module bb3_datapath #(
    parameter int  MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bb3_pkg::dp_cmd_t         cmd,
    input  logic [AW-1:0]            rd_addr,
    input  logic [AW-1:0]            wr_addr,
    input  logic [bb3_pkg::CH_W-1:0] pix_red,
    input  logic [bb3_pkg::CH_W-1:0] pix_green,
    input  logic [bb3_pkg::CH_W-1:0] pix_blue,
    output bb3_pkg::dp_status_t      status,
    bb3_out_if.source                blurred
);

    localparam int NCH  = bb3_pkg::NUM_CH;
    localparam int CHW  = bb3_pkg::CH_W;
    localparam int PXW  = bb3_pkg::PIX_W;
    localparam int SMW  = bb3_pkg::SUM_W;
    localparam int CNW  = bb3_pkg::CNT_W;
    localparam int PRW  = bb3_pkg::PROD_W;
    localparam int FRW  = bb3_pkg::FRAC_W;

    logic [PXW-1:0] older_rd;
    logic [PXW-1:0] newer_rd;

    // window [column][row], column 0 oldest, row 0 oldest
    logic [PXW-1:0] win_reg  [3][3];
    logic [PXW-1:0] win_next [3][3];
    logic [PXW-1:0] pix_reg;
    logic [PXW-1:0] pix_next;
    logic [SMW-1:0] acc_reg  [NCH];
    logic [SMW-1:0] acc_next [NCH];
    logic [CNW-1:0] n_reg;
    logic [CNW-1:0] n_next;
    logic [PRW-1:0] prod_reg  [NCH];
    logic [PRW-1:0] prod_next [NCH];
    logic [CHW-1:0] out_ch_reg  [NCH];
    logic [CHW-1:0] out_ch_next [NCH];
    logic           fend_reg;
    logic           fend_next;
    logic           rend_reg;
    logic           rend_next;
    logic           out_valid_reg;
    logic           out_valid_next;

    logic [SMW-1:0] win_sum [NCH];
    logic [SMW-1:0] ram_sum [NCH];
    logic [CNW-1:0] ncols;
    logic [CNW-1:0] nrows;
    logic [CNW-1:0] nwin;
    logic [CNW-1:0] nram;
    logic [bb3_pkg::RECIP_W-1:0] recip_val;

    bb3_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (cmd.shift),
        .waddr (wr_addr),
        .wdata (newer_rd),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (older_rd)
    );

    bb3_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (cmd.shift),
        .waddr (wr_addr),
        .wdata (pix_reg),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (newer_rd)
    );

    assign status.out_free = !out_valid_reg || blurred.ready;

    assign blurred.valid     = out_valid_reg;
    assign blurred.out_red   = out_ch_reg[0];
    assign blurred.out_green = out_ch_reg[1];
    assign blurred.out_blue  = out_ch_reg[2];
    assign blurred.frame_end = fend_reg;
    assign blurred.run_end   = rend_reg;

    always_comb
    begin
        ncols = CNW'(cmd.col_mask[0]) + CNW'(cmd.col_mask[1]) + CNW'(cmd.col_mask[2]);
        nrows = CNW'(cmd.row_mask[0]) + CNW'(cmd.row_mask[1]) + CNW'(cmd.row_mask[2]);
        nwin  = ncols * nrows;
        nram  = CNW'(cmd.row_mask[0]) + CNW'(cmd.row_mask[1]);
        recip_val = bb3_pkg::recip(n_reg);

        for (int ch = 0; ch < NCH; ch++)
        begin
            win_sum[ch] = '0;
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    if (cmd.col_mask[c] && cmd.row_mask[r])
                    begin
                        win_sum[ch] = win_sum[ch]
                                    + SMW'(win_reg[c][r][(NCH-1-ch)*CHW +: CHW]);
                    end
                end
            end
            ram_sum[ch] = acc_reg[ch]
                        + (cmd.row_mask[0] ? SMW'(older_rd[(NCH-1-ch)*CHW +: CHW]) : '0)
                        + (cmd.row_mask[1] ? SMW'(newer_rd[(NCH-1-ch)*CHW +: CHW]) : '0);
        end
    end

    always_comb
    begin
        win_next    = win_reg;
        pix_next    = pix_reg;
        acc_next    = acc_reg;
        n_next      = n_reg;
        prod_next   = prod_reg;
        out_ch_next = out_ch_reg;
        fend_next   = fend_reg;
        rend_next   = rend_reg;

        if (cmd.capture)
        begin
            pix_next = {pix_red, pix_green, pix_blue};
        end
        if (cmd.shift)
        begin
            win_next[0]    = win_reg[1];
            win_next[1]    = win_reg[2];
            win_next[2][0] = older_rd;
            win_next[2][1] = newer_rd;
            win_next[2][2] = pix_reg;
        end
        if (cmd.sum)
        begin
            acc_next = win_sum;
            n_next   = nwin;
        end
        if (cmd.clr)
        begin
            for (int ch = 0; ch < NCH; ch++)
            begin
                acc_next[ch] = '0;
            end
            n_next = '0;
        end
        if (cmd.acc)
        begin
            acc_next = ram_sum;
            n_next   = n_reg + nram;
        end
        if (cmd.mul)
        begin
            for (int ch = 0; ch < NCH; ch++)
            begin
                prod_next[ch] = PRW'(acc_reg[ch]) * PRW'(recip_val);
            end
        end
        if (cmd.load_out)
        begin
            for (int ch = 0; ch < NCH; ch++)
            begin
                out_ch_next[ch] = prod_reg[ch][FRW +: CHW];
            end
            fend_next = cmd.frame_end;
            rend_next = cmd.run_end;
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (blurred.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg    <= win_next;
        pix_reg    <= pix_next;
        acc_reg    <= acc_next;
        n_reg      <= n_next;
        prod_reg   <= prod_next;
        out_ch_reg <= out_ch_next;
        fend_reg   <= fend_next;
        rend_reg   <= rend_next;
    end

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over an untaken result");

    a_divisor_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> (n_reg == 4'd1 || n_reg == 4'd2 || n_reg == 4'd3 ||
                     n_reg == 4'd4 || n_reg == 4'd6 || n_reg == 4'd9))
        else $error("neighbor count outside divisor set");

    a_acc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |-> $past(cmd.rd_en))
        else $error("row buffer data used without a read");

endmodule

// File: sv/bb3_ctrl.sv
// Controller: frame position counters, drain tracking, config registers and sequencer.
module bb3_ctrl #(
    parameter int  MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    bb3_in_if.sink                         pixels,
    input  bb3_pkg::dp_status_t            status,
    output bb3_pkg::dp_cmd_t               cmd,
    output logic [AW-1:0]                  rd_addr,
    output logic [AW-1:0]                  wr_addr
);

    localparam int WW = bb3_pkg::WIDTH_W;
    localparam int HW = bb3_pkg::HEIGHT_W;
    localparam int RW = bb3_pkg::ROW_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SUM,
        S_MUL,
        S_OUT,
        S_DREAD,
        S_DACC
    } state_t;

    state_t        state_reg, state_next;
    logic [WW-1:0] w_reg, w_next;
    logic [HW-1:0] h_reg, h_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] col_reg, col_next;
    logic [WW-1:0] drain_reg, drain_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [2:0]    col_mask_reg, col_mask_next;
    logic [2:0]    col_mask2_reg, col_mask2_next;
    logic [2:0]    row_mask_reg, row_mask_next;
    logic          pend2_reg, pend2_next;
    logic          fend_reg, fend_next;
    logic          rend_reg, rend_next;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [HW-1:0] c13;
    logic [HW-1:0] r13;
    logic [HW-1:0] w13;
    logic          accept;
    logic          row_end;
    logic          emit1;
    logic          emit2;
    logic [2:0]    mask_first;
    logic [2:0]    mask_second;
    logic [WW-1:0] k;
    logic [WW-1:0] lo;
    logic [WW-1:0] hi;

    always_comb
    begin
        if (w_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(w_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_reg;
        end

        if (h_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (h_reg > HW'(bb3_pkg::HEIGHT_CAP))
        begin
            h_eff = HW'(bb3_pkg::HEIGHT_CAP);
        end
        else
        begin
            h_eff = h_reg;
        end
    end

    assign pixels.ready = (state_reg == S_IDLE);
    assign accept       = pixels.valid && pixels.ready;
    assign rd_addr      = (state_reg == S_DREAD) ? j_reg : col_reg;
    assign wr_addr      = col_reg;

    assign c13         = HW'(col_reg);
    assign r13         = HW'(row_reg);
    assign w13         = HW'(w_eff);
    assign row_end     = (c13 + HW'(1)) >= w13;
    assign emit1       = (row_reg != '0) && (col_reg != '0);
    assign emit2       = (row_reg != '0) && row_end;
    assign mask_first  = (c13 >= HW'(2)) ? 3'b111 : 3'b110;
    assign mask_second = (col_reg != '0) ? 3'b110 : 3'b100;

    // drain column k = w - pending, neighborhood k-1..k+1 clipped to the row
    assign k  = w_eff - drain_reg;
    assign lo = (k == '0) ? '0 : k - WW'(1);
    assign hi = ((HW'(k) + HW'(1)) < w13) ? k + WW'(1) : k;

    always_comb
    begin
        state_next     = state_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        drain_next     = drain_reg;
        j_next         = j_reg;
        hi_next        = hi_reg;
        col_mask_next  = col_mask_reg;
        col_mask2_next = col_mask2_reg;
        row_mask_next  = row_mask_reg;
        pend2_next     = pend2_reg;
        fend_next      = fend_reg;
        rend_next      = rend_reg;

        cmd           = '0;
        cmd.col_mask  = col_mask_reg;
        cmd.row_mask  = row_mask_reg;
        cmd.frame_end = fend_reg;
        cmd.run_end   = rend_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.rd_en = 1'b1;
                if (accept)
                begin
                    if (!pixels.req_type)
                    begin
                        // pixels are dropped while the final row drains
                        if (drain_reg == '0)
                        begin
                            cmd.capture = 1'b1;
                            state_next  = S_SHIFT;
                        end
                    end
                    else if (drain_reg == '0 || drain_reg > w_eff)
                    begin
                        drain_next = '0;
                    end
                    else
                    begin
                        cmd.clr       = 1'b1;
                        j_next        = AW'(lo);
                        hi_next       = AW'(hi);
                        row_mask_next = {1'b0, 1'b1, (h_eff >= HW'(2))};
                        fend_next     = (drain_reg == WW'(1));
                        rend_next     = 1'b1;
                        drain_next    = drain_reg - WW'(1);
                        state_next    = S_DREAD;
                    end
                end
            end

            S_SHIFT:
            begin
                cmd.shift     = 1'b1;
                row_mask_next = (r13 >= HW'(2)) ? 3'b111 : 3'b110;
                fend_next     = 1'b0;
                if (emit1)
                begin
                    col_mask_next  = mask_first;
                    col_mask2_next = mask_second;
                    rend_next      = !row_end;
                    pend2_next     = emit2;
                    state_next     = S_SUM;
                end
                else if (emit2)
                begin
                    col_mask_next = mask_second;
                    rend_next     = 1'b1;
                    pend2_next    = 1'b0;
                    state_next    = S_SUM;
                end
                else
                begin
                    state_next = S_IDLE;
                end

                if (row_end)
                begin
                    col_next = '0;
                    if ((r13 + HW'(1)) >= h_eff)
                    begin
                        row_next   = '0;
                        drain_next = w_eff;
                    end
                    else
                    begin
                        row_next = row_reg + RW'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + AW'(1);
                end
            end

            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (pend2_reg)
                    begin
                        col_mask_next = col_mask2_reg;
                        rend_next     = 1'b1;
                        pend2_next    = 1'b0;
                        state_next    = S_SUM;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_DREAD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_DACC;
            end

            S_DACC:
            begin
                cmd.acc = 1'b1;
                if (j_reg == hi_reg)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    j_next     = j_reg + AW'(1);
                    state_next = S_DREAD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // any register write restarts the frame
        if (cfg_we)
        begin
            unique case (cfg_index)
                bb3_pkg::REG_IMAGE_WIDTH:
                begin
                    w_next = cfg_data[WW-1:0];
                end
                bb3_pkg::REG_IMAGE_HEIGHT:
                begin
                    h_next = cfg_data[HW-1:0];
                end
                default:
                begin
                    h_next = h_reg;
                end
            endcase
            row_next   = '0;
            col_next   = '0;
            drain_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            w_reg         <= WW'(bb3_pkg::WIDTH_RESET);
            h_reg         <= HW'(bb3_pkg::HEIGHT_RESET);
            row_reg       <= '0;
            col_reg       <= '0;
            drain_reg     <= '0;
            j_reg         <= '0;
            hi_reg        <= '0;
            col_mask_reg  <= '0;
            col_mask2_reg <= '0;
            row_mask_reg  <= '0;
            pend2_reg     <= 1'b0;
            fend_reg      <= 1'b0;
            rend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            w_reg         <= w_next;
            h_reg         <= h_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            drain_reg     <= drain_next;
            j_reg         <= j_next;
            hi_reg        <= hi_next;
            col_mask_reg  <= col_mask_next;
            col_mask2_reg <= col_mask2_next;
            row_mask_reg  <= row_mask_next;
            pend2_reg     <= pend2_next;
            fend_reg      <= fend_next;
            rend_reg      <= rend_next;
        end
    end

    a_drain_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg <= w_eff)
        else $error("drain count beyond row width");

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        c13 < w13)
        else $error("column counter beyond row width");

    a_pixel_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !pixels.req_type && drain_reg != '0 |=> state_reg == S_IDLE)
        else $error("pixel request processed during drain");

    a_drain_loop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DACC |=> state_reg == S_DREAD || state_reg == S_MUL)
        else $error("drain accumulation left its loop");

endmodule

// File: sv/box_blur_3x3_stream.sv
// Top level of the streaming 3x3 RGB box blur.
// Requests are taken one at a time. A pixel request that yields no result goes from shift
// back to idle; one with a result also passes sum, multiply and output, one that ends a
// row (two results) passes those twice, and output waits on a stalled consumer. A drain
// request reads and accumulates each of its 1 to 3 neighboring columns in turn from the
// registered-read row buffers through the single read port. Division by the neighbor
// count is a reciprocal multiply with one register after it. Results sit in an output
// register, so a new request is taken while the last result waits. The row buffers need
// no clearing pass after reset: no entry is used before this frame writes it. Register
// writes restart the frame and are to be made while idle; the block does not enforce this.
module box_blur_3x3_stream #(
    parameter int  MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
    localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    bb3_in_if.sink                         pixels,
    bb3_out_if.source                      blurred
);

    bb3_pkg::dp_cmd_t    cmd;
    bb3_pkg::dp_status_t status;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;

    bb3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels),
        .status    (status),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    bb3_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .pix_red   (pixels.in_red),
        .pix_green (pixels.in_green),
        .pix_blue  (pixels.in_blue),
        .status    (status),
        .blurred   (blurred)
    );

endmodule

// File: tb/box_blur_3x3_stream_tb.sv
// Self-checking testbench for the 3x3 box blur: random and border-case frames, scoreboarded.
module box_blur_3x3_stream_tb;

    localparam logic REQ_PIXEL     = 1'b0;
    localparam logic REQ_DRAIN     = 1'b1;
    localparam int   SETTLE_CYCLES = 20;
    localparam int   MAX_REPORTS   = 40;
    localparam int   RANDOM_ITEMS  = 160;

    typedef struct packed {
        logic [bb3_pkg::CH_W-1:0] red;
        logic [bb3_pkg::CH_W-1:0] green;
        logic [bb3_pkg::CH_W-1:0] blue;
        logic                     frame_end;
        logic                     run_end;
    } blur_px_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data;

    bb3_in_if  pixels();
    bb3_out_if blurred();

    box_blur_3x3_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels),
        .blurred   (blurred)
    );

    logic [bb3_pkg::WIDTH_W-1:0]  cur_width;
    logic [bb3_pkg::HEIGHT_W-1:0] cur_height;
    logic [bb3_pkg::PIX_W-1:0]    older_row [bb3_pkg::MAX_WIDTH_DEF];
    logic [bb3_pkg::PIX_W-1:0]    newer_row [bb3_pkg::MAX_WIDTH_DEF];
    logic [bb3_pkg::PIX_W-1:0]    window [9];
    int unsigned                  row_pos;
    int unsigned                  col_pos;
    int unsigned                  drain_left;
    int unsigned                  sum_r, sum_g, sum_b, n_acc;
    blur_px_t                     pending_blur [$];
    int                           mismatches = 0;
    bit                           idle_on = 1'b1;
    int unsigned                  stall_left = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned eff_width();
        if (cur_width == 0)
            return 1;
        if (cur_width > bb3_pkg::MAX_WIDTH_DEF)
            return bb3_pkg::MAX_WIDTH_DEF;
        return cur_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cur_height == 0)
            return 1;
        if (cur_height > bb3_pkg::HEIGHT_CAP)
            return bb3_pkg::HEIGHT_CAP;
        return cur_height;
    endfunction

    function automatic void restart_frame();
        row_pos    = 0;
        col_pos    = 0;
        drain_left = 0;
    endfunction

    function automatic void reset_predictor();
        for (int j = 0; j < bb3_pkg::MAX_WIDTH_DEF; j++)
        begin
            older_row[j] = '0;
            newer_row[j] = '0;
        end
        for (int j = 0; j < 9; j++)
            window[j] = '0;
        cur_width  = bb3_pkg::WIDTH_W'(bb3_pkg::WIDTH_RESET);
        cur_height = bb3_pkg::HEIGHT_W'(bb3_pkg::HEIGHT_RESET);
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        n_acc = 0;
        restart_frame();
    endfunction

    function automatic void apply_config(input logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [bb3_pkg::CFG_DATA_W-1:0] value);
        if (idx == bb3_pkg::REG_IMAGE_WIDTH)
            cur_width = value[bb3_pkg::WIDTH_W-1:0];
        else
            cur_height = value[bb3_pkg::HEIGHT_W-1:0];
        restart_frame();
    endfunction

    function automatic void acc_px(input logic [bb3_pkg::PIX_W-1:0] p);
        sum_r += p[23:16];
        sum_g += p[15:8];
        sum_b += p[7:0];
        n_acc++;
    endfunction

    function automatic void push_mean(input logic fend, input logic rend);
        blur_px_t e;
        e.red       = bb3_pkg::CH_W'(sum_r / n_acc);
        e.green     = bb3_pkg::CH_W'(sum_g / n_acc);
        e.blue      = bb3_pkg::CH_W'(sum_b / n_acc);
        e.frame_end = fend;
        e.run_end   = rend;
        pending_blur.push_back(e);
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        n_acc = 0;
    endfunction

    // window index is col*3+row, oldest column and oldest row first
    function automatic void gather_window(input int unsigned c0, input int unsigned r0);
        for (int unsigned cc = c0; cc < 3; cc++)
            for (int unsigned rr = r0; rr < 3; rr++)
                acc_px(window[cc * 3 + rr]);
    endfunction

    function automatic void predict_blur(input logic kind,
                                         input logic [bb3_pkg::PIX_W-1:0] pix);
        int unsigned w, h, r, c, k, j, lo, hi, r0;
        bit          row_end;
        w = eff_width();
        h = eff_height();
        if (kind == REQ_DRAIN)
        begin
            if (drain_left == 0 || drain_left > w)
            begin
                drain_left = 0;
                return;
            end
            k  = w - drain_left;
            lo = (k == 0) ? 0 : k - 1;
            hi = (k + 1 < w) ? k + 1 : k;
            for (j = lo; j <= hi; j++)
            begin
                if (h >= 2)
                    acc_px(older_row[j]);
                acc_px(newer_row[j]);
            end
            drain_left--;
            push_mean(drain_left == 0, 1'b1);
            if (drain_left == 0)
                restart_frame();
            return;
        end
        if (drain_left != 0)
            return;
        r = row_pos;
        c = col_pos;
        if (c >= w || r >= h)
        begin
            restart_frame();
            r = 0;
            c = 0;
        end
        for (j = 0; j < 6; j++)
            window[j] = window[j + 3];
        window[6]    = older_row[c];
        window[7]    = newer_row[c];
        window[8]    = pix;
        older_row[c] = newer_row[c];
        newer_row[c] = pix;
        if (r >= 1)
        begin
            r0      = (r >= 2) ? 0 : 1;
            row_end = (c == w - 1);
            if (c >= 1)
            begin
                gather_window((c >= 2) ? 0 : 1, r0);
                push_mean(1'b0, !row_end);
            end
            if (row_end)
            begin
                gather_window((c >= 1) ? 1 : 2, r0);
                push_mean(1'b0, 1'b1);
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            if (r + 1 >= h)
            begin
                r          = 0;
                drain_left = w;
            end
            else
                r++;
        end
        row_pos = r;
        col_pos = c;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, exp_val);
    endtask

    always @(posedge clk)
    begin : check_result
        blur_px_t want;
        if (rst_n === 1'b1 && blurred.valid === 1'b1 && blurred.ready === 1'b1)
        begin
            if (pending_blur.size() == 0)
                report_mismatch("result with none pending, out_red", blurred.out_red, 0);
            else
            begin
                want = pending_blur.pop_front();
                if (blurred.out_red !== want.red)
                    report_mismatch("out_red", blurred.out_red, want.red);
                if (blurred.out_green !== want.green)
                    report_mismatch("out_green", blurred.out_green, want.green);
                if (blurred.out_blue !== want.blue)
                    report_mismatch("out_blue", blurred.out_blue, want.blue);
                if (blurred.frame_end !== want.frame_end)
                    report_mismatch("frame_end", blurred.frame_end, want.frame_end);
                if (blurred.run_end !== want.run_end)
                    report_mismatch("run_end", blurred.run_end, want.run_end);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_on && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 6);
        blurred.ready <= (stall_left == 0);
    end

    task automatic send_req(input logic kind, input logic [bb3_pkg::PIX_W-1:0] pix);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            pixels.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pixels.valid    <= 1'b1;
        pixels.req_type <= kind;
        pixels.in_red   <= pix[23:16];
        pixels.in_green <= pix[15:8];
        pixels.in_blue  <= pix[7:0];
        @(posedge clk);
        while (pixels.ready !== 1'b1)
            @(posedge clk);
        predict_blur(kind, pix);
    endtask

    task automatic send_random_pixels(input int unsigned count);
        repeat (count) send_req(REQ_PIXEL, bb3_pkg::PIX_W'($urandom));
    endtask

    task automatic send_drains(input int unsigned count);
        repeat (count) send_req(REQ_DRAIN, bb3_pkg::PIX_W'($urandom));
    endtask

    task automatic wait_idle();
        pixels.valid <= 1'b0;
        while (pending_blur.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[bb3_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        apply_config(idx, value[bb3_pkg::CFG_DATA_W-1:0]);
    endtask

    function automatic logic [bb3_pkg::PIX_W-1:0] corner_px(input int unsigned i);
        case (i)
            0:       return 24'hFFFFFF;
            1:       return 24'h000000;
            2:       return 24'hFFFFFF;
            3:       return 24'hAA55FF;
            4:       return 24'hFFFFFF;
            5:       return 24'h55AA00;
            6:       return 24'hFFFFFF;
            7:       return 24'h010203;
            default: return 24'hFEFDFC;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_random_pixels(3);
    endtask

    task automatic test_border_divisors();
        wait_idle();
        write_reg(bb3_pkg::REG_IMAGE_WIDTH, 3);
        write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 3);
        for (int unsigned i = 0; i < 9; i++)
            send_req(REQ_PIXEL, corner_px(i));
        send_req(REQ_PIXEL, 24'h123456);
        send_drains(3);
        send_req(REQ_DRAIN, 24'hFFFFFF);
        // zero width and height act as one
        wait_idle();
        write_reg(bb3_pkg::REG_IMAGE_WIDTH, 0);
        write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 0);
        send_req(REQ_PIXEL, 24'hFF00FF);
        send_req(REQ_PIXEL, 24'h00FF00);
        send_req(REQ_DRAIN, 24'h000000);
        wait_idle();
        write_reg(bb3_pkg::REG_IMAGE_WIDTH, 3);
        write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 1);
        for (int unsigned i = 0; i < 3; i++)
            send_req(REQ_PIXEL, corner_px(8 - i));
        send_drains(3);
    endtask

    task automatic test_random_frames();
        int unsigned counted, w, h, cut, ndrain, shape;
        bit          clean;
        counted = 0;
        clean   = 1'b0;
        w       = 1;
        h       = 1;
        while (counted < RANDOM_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (!clean || $urandom_range(0, 1) == 0)
            begin
                wait_idle();
                if (!clean || $urandom_range(0, 3) != 0)
                begin
                    w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                    write_reg(bb3_pkg::REG_IMAGE_WIDTH, w);
                end
                h = $urandom_range(1, 6);
                write_reg(bb3_pkg::REG_IMAGE_HEIGHT, h);
            end
            shape = $urandom_range(0, 9);
            cut   = (shape == 0) ? $urandom_range(1, w * h) : w * h;
            for (int unsigned i = 0; i < cut; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_drains(1);
                send_random_pixels(1);
                counted++;
            end
            if (shape == 0)
                clean = 1'b0;
            else
            begin
                ndrain = (shape == 1) ? $urandom_range(0, w - 1) : w;
                for (int unsigned i = 0; i < ndrain; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_random_pixels(1);
                    send_drains(1);
                    counted++;
                end
                clean = (shape != 1);
                if (clean && $urandom_range(0, 7) == 0)
                    send_drains(1);
            end
        end
        idle_on = 1'b1;
    endtask

    // oversize width acts as the maximum: the frame ends after one maximum-width row
    task automatic test_width_limits();
        wait_idle();
        write_reg(bb3_pkg::REG_IMAGE_WIDTH, 2047);
        write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 1);
        send_random_pixels(bb3_pkg::MAX_WIDTH_DEF);
        send_drains(2);
        send_random_pixels(1);
    endtask

    task automatic test_height_limits();
        idle_on = 1'b0;
        wait_idle();
        write_reg(bb3_pkg::REG_IMAGE_WIDTH, 1);
        write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 8191);
        send_random_pixels(8);
        send_drains(1);
        send_random_pixels(1);
        idle_on = 1'b1;
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        wait_idle();
        write_reg(bb3_pkg::REG_IMAGE_WIDTH, 5);
        write_reg(bb3_pkg::REG_IMAGE_HEIGHT, 4);
        repeat (3)
        begin
            send_random_pixels(20);
            send_drains(5);
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= bb3_pkg::REG_IMAGE_WIDTH;
        cfg_data        <= '0;
        pixels.valid    <= 1'b0;
        pixels.req_type <= REQ_PIXEL;
        pixels.in_red   <= '0;
        pixels.in_green <= '0;
        pixels.in_blue  <= '0;
        reset_predictor();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_border_divisors();
        test_random_frames();
        test_width_limits();
        test_height_limits();
        test_full_rate();
        wait_idle();
        if (mismatches == 0)
            $display("PASS box_blur_3x3_stream");
        else
            $display("FAIL box_blur_3x3_stream");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL box_blur_3x3_stream");
        $finish;
    end

endmodule
